// ===== rtl/eck_pkg.sv =====
package eck_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 17;
  localparam int SqW    = 32;
  localparam int SumW   = 33;
  localparam int RootW  = 17;
  localparam int RemW   = 35;
  localparam int ScaleW = 16;
  localparam int ProdW  = 33;
  localparam int ExpTerms = 20;
  localparam int AccW   = 31;
  localparam int FacW   = 30;
  localparam int CovW   = 16;

  localparam logic [ScaleW-1:0] ScaleReset = 16'd256;
  localparam logic [AccW-1:0]   AccOne     = 31'd1073741824;

  function automatic logic [FacW-1:0] exp_factor(input logic [4:0] k);
    logic [FacW-1:0] f;
    case (k)
      5'd0:  f = 30'd1073725440;
      5'd1:  f = 30'd1073709056;
      5'd2:  f = 30'd1073676290;
      5'd3:  f = 30'd1073610760;
      5'd4:  f = 30'd1073479712;
      5'd5:  f = 30'd1073217664;
      5'd6:  f = 30'd1072693760;
      5'd7:  f = 30'd1071646719;
      5'd8:  f = 30'd1069555701;
      5'd9:  f = 30'd1065385899;
      5'd10: f = 30'd1057095000;
      5'd11: f = 30'd1040706261;
      5'd12: f = 30'd1008687096;
      5'd13: f = 30'd947573834;
      5'd14: f = 30'd836230973;
      5'd15: f = 30'd651257337;
      5'd16: f = 30'd395007542;
      5'd17: f = 30'd145315154;
      5'd18: f = 30'd19666268;
      5'd19: f = 30'd360200;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/eck_if.sv =====
interface eck_pair_if;
  import eck_pkg::*;
  logic valid;
  logic ready;
  logic signed [CoordW-1:0] a_x;
  logic signed [CoordW-1:0] a_y;
  logic signed [CoordW-1:0] b_x;
  logic signed [CoordW-1:0] b_y;
  modport source (output valid, a_x, a_y, b_x, b_y, input ready);
  modport sink (input valid, a_x, a_y, b_x, b_y, output ready);
endinterface

interface eck_cov_if;
  import eck_pkg::*;
  logic valid;
  logic ready;
  logic [CovW-1:0] covariance;
  modport source (output valid, covariance, input ready);
  modport sink (input valid, covariance, output ready);
endinterface

interface eck_cfg_if;
  import eck_pkg::*;
  logic valid;
  logic ready;
  logic [ScaleW-1:0] inv_length_scale;
  modport source (output valid, inv_length_scale, input ready);
  modport sink (input valid, inv_length_scale, output ready);
endinterface

// ===== rtl/eck_dist_sq.sv =====
module eck_dist_sq
  import eck_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [CoordW-1:0] a_x,
  input  logic signed [CoordW-1:0] a_y,
  input  logic signed [CoordW-1:0] b_x,
  input  logic signed [CoordW-1:0] b_y,
  output logic                     sum_valid,
  output logic [SumW-1:0]          sum
);

  logic                    v1, v2;
  logic signed [DiffW-1:0] dx, dy;
  logic [SqW-1:0]          sqx, sqy;
  logic signed [2*DiffW-1:0] px, py;

  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      sum_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      sum_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx  <= DiffW'(b_x) - DiffW'(a_x);
      dy  <= DiffW'(b_y) - DiffW'(a_y);
      sqx <= px[SqW-1:0];
      sqy <= py[SqW-1:0];
      sum <= SumW'(sqx) + SumW'(sqy);
    end
  end

endmodule

// ===== rtl/eck_sqrt.sv =====
module eck_sqrt
  import eck_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SumW-1:0]  sum,
  output logic             root_valid,
  output logic [RootW-1:0] root
);

  logic             v   [0:RootW];
  logic [RemW-1:0]  rem [0:RootW];
  logic [RootW-1:0] rt  [0:RootW];

  assign v[0]   = in_valid;
  assign rem[0] = RemW'(sum);
  assign rt[0]  = '0;

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int B = RootW - 1 - j;
    logic [RemW-1:0] trial;
    assign trial = (RemW'(rt[j]) << (B + 1)) + (RemW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[j] >= trial) begin
          rem[j+1] <= rem[j] - trial;
          rt[j+1]  <= rt[j] | (RootW'(1) << B);
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= rt[j];
        end
      end
    end
  end

  assign root_valid = v[RootW];
  assign root       = rt[RootW];

endmodule

// ===== rtl/eck_exp.sv =====
module eck_exp
  import eck_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RootW-1:0]  root,
  input  logic [ScaleW-1:0] scale,
  output logic              cov_valid,
  output logic [CovW-1:0]   cov
);

  logic                  v    [0:ExpTerms];
  logic [AccW-1:0]       acc  [0:ExpTerms];
  logic [ExpTerms-1:0]   tb   [0:ExpTerms];
  logic                  big  [0:ExpTerms];
  logic [ProdW-1:0]      t;
  logic [AccW:0]         rnd;

  assign t = ProdW'(root) * ProdW'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= AccOne;
      tb[0]  <= t[ExpTerms-1:0];
      big[0] <= |t[ProdW-1:ExpTerms];
    end
  end

  for (genvar k = 0; k < ExpTerms; k++) begin : g_term
    logic [AccW+FacW-1:0] prod;
    assign prod = (AccW+FacW)'(acc[k]) * (AccW+FacW)'(exp_factor(5'(k)))
                  + ((AccW+FacW)'(1) << 29);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k+1] <= tb[k][k] ? prod[30 +: AccW] : acc[k];
        tb[k+1]  <= tb[k];
        big[k+1] <= big[k];
      end
    end
  end

  assign rnd = ((AccW+1)'(acc[ExpTerms]) + (AccW+1)'(14'h2000)) >> 14;

  always_ff @(posedge clk) begin
    if (rst) begin
      cov_valid <= 1'b0;
    end else if (en) begin
      cov_valid <= v[ExpTerms];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (big[ExpTerms]) begin
        cov <= '0;
      end else if (|rnd[AccW:CovW]) begin
        cov <= '1;
      end else begin
        cov <= rnd[CovW-1:0];
      end
    end
  end

endmodule

// ===== rtl/exponential_covariance_kernel.sv =====
// Exponential covariance kernel: each transfer on pairs carries two Q8.8 points and
// yields one Q0.16 covariance exp(-|b-a| * inv_length_scale) on result, saturated to
// 65535 at zero distance. One item enters per cycle while pairs.ready is high. Items
// pass through the difference/square stages, a 17-stage bit-per-stage square root,
// the scale multiply, a 20-stage product chain for the exponential and a rounding
// stage, plus the output register. A skid stage at the output keeps pairs.ready a
// register. Write inv_length_scale through cfg only while no item is in flight.
module exponential_covariance_kernel
  import eck_pkg::*;
(
  input  logic clk,
  input  logic rst,
  eck_pair_if.sink  pairs,
  eck_cov_if.source result,
  eck_cfg_if.sink   cfg
);

  logic              en;
  logic [ScaleW-1:0] scale;
  logic              sum_valid, root_valid, p_valid;
  logic [SumW-1:0]   sum;
  logic [RootW-1:0]  root;
  logic [CovW-1:0]   p_cov;
  logic              out_valid, skid_valid;
  logic [CovW-1:0]   out_cov, skid_cov;
  logic              emit;

  assign en          = !skid_valid;
  assign pairs.ready = en;
  assign cfg.ready   = 1'b1;
  assign emit        = en && p_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= ScaleReset;
    end else if (cfg.valid) begin
      scale <= cfg.inv_length_scale;
    end
  end

  eck_dist_sq u_dist (
    .clk, .rst, .en,
    .in_valid (pairs.valid),
    .a_x (pairs.a_x), .a_y (pairs.a_y), .b_x (pairs.b_x), .b_y (pairs.b_y),
    .sum_valid, .sum
  );

  eck_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_valid (sum_valid), .sum,
    .root_valid, .root
  );

  eck_exp u_exp (
    .clk, .rst, .en,
    .in_valid (root_valid), .root, .scale,
    .cov_valid (p_valid), .cov (p_cov)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid  <= skid_valid || emit;
      skid_valid <= 1'b0;
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      out_cov <= skid_valid ? skid_cov : p_cov;
    end else if (emit) begin
      skid_cov <= p_cov;
    end
  end

  assign result.valid      = out_valid;
  assign result.covariance = out_cov;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds data with empty output");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |=> out_valid) else $error("stalled result dropped");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !result.ready && p_valid))
    else $error("skid filled without a stall");
`endif

endmodule
